// File: hdl/iidl_pkg.sv
package iidl_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  // common width for comparing position, count and cell index
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
  } shift_ctrl_t;

endpackage

// File: hdl/iidl_cell.sv
module iidl_cell (
  input  logic                        clk,
  input  logic [iidl_pkg::IDX_W-1:0]  idx,
  input  iidl_pkg::shift_ctrl_t       ctrl,
  input  logic [iidl_pkg::DATA_W-1:0] data_in,
  input  logic [iidl_pkg::DATA_W-1:0] left,
  input  logic [iidl_pkg::DATA_W-1:0] right,
  output logic [iidl_pkg::DATA_W-1:0] value
);
  import iidl_pkg::*;

  logic [CMP_W-1:0]  idx_x;
  logic [DATA_W-1:0] value_next;

  assign idx_x = CMP_W'(idx);

  always_comb begin
    value_next = value;
    if (ctrl.ins) begin
      // insert: cells above the target take the lower neighbor
      if (idx_x > ctrl.pos) begin
        value_next = left;
      end else if (idx_x == ctrl.pos) begin
        value_next = data_in;
      end
    end else if (ctrl.del) begin
      if (idx_x >= ctrl.pos) begin
        value_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: hdl/indexed_insert_delete_list.sv
// Channel  Direction  Handshake               Fields
// in       input      in_valid / in_stall     command, position, data_in
// out      output     out_valid / out_stall   read_data, status, entry_count
//
// One command per cycle while in_stall is low; every cell of the chain shifts in the same cycle, and
// the result appears in the output register in the cycle after the input beat.
// rst clears the count and the output valid; cell contents are not reset.
// in_stall is high while a result beat is held by out_stall.
module indexed_insert_delete_list (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [iidl_pkg::CMD_W-1:0]          command,
  input  logic [iidl_pkg::POS_W-1:0]          position,
  input  logic signed [iidl_pkg::DATA_W-1:0]  data_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [iidl_pkg::DATA_W-1:0]  read_data,
  output logic [iidl_pkg::STAT_W-1:0]         status,
  output logic [iidl_pkg::POS_W-1:0]          entry_count
);
  import iidl_pkg::*;

  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_count_next;
  logic [DATA_W-1:0] vals [DEPTH];
  shift_ctrl_t       ctrl;

  logic              accept;
  logic              full;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  cnt_after_x;
  logic [DATA_W-1:0] rd_sel;
  logic [DATA_W-1:0] rd;
  status_t           st;
  logic              do_ins;
  logic              do_del;
  logic [CMP_W-1:0]  ins_pos;

  status_t           status_q;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign pos_x    = CMP_W'(position);
  assign cnt_x    = CMP_W'(fill_count);
  assign full     = (fill_count == CNT_W'(DEPTH));

  // one-hot select of the addressed cell
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_x == CMP_W'(i)) begin
        rd_sel = rd_sel | vals[i];
      end
    end
  end

  always_comb begin
    st      = ST_OK;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_pos = pos_x;
    rd      = '0;
    unique case (cmd_t'(command))
      CMD_APPEND: begin
        ins_pos = cnt_x;
        if (full) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          st = ST_BOUNDS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_x >= cnt_x) begin
          st = ST_BOUNDS;
        end else begin
          do_del = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_x >= cnt_x) begin
          st = ST_BOUNDS;
          rd = '1;
        end else begin
          rd = rd_sel;
        end
      end
      default: ;
    endcase
  end

  assign ctrl.ins = accept && do_ins;
  assign ctrl.del = accept && do_del;
  assign ctrl.pos = ins_pos;

  always_comb begin
    fill_count_next = fill_count;
    if (ctrl.ins) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (ctrl.del) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  assign cnt_after_x = CMP_W'(fill_count_next);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = data_in;
    end else begin : g_mid_l
      assign left_v = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = vals[g];
    end else begin : g_mid_r
      assign right_v = vals[g+1];
    end
    iidl_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(g)),
      .ctrl    (ctrl),
      .data_in (data_in),
      .left    (left_v),
      .right   (right_v),
      .value   (vals[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data   <= rd;
      status_q    <= st;
      entry_count <= cnt_after_x[POS_W-1:0];
    end
  end

  assign status = status_q;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count == cnt_x[POS_W-1:0])
    else $error("reported count differs from stored count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_q == ST_FULL |-> full)
    else $error("full status while not full");

  a_no_shift_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !ctrl.ins && !ctrl.del)
    else $error("chain shifted while input stalled");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_t'(command) == CMD_APPEND && !full |=>
      fill_count == $past(fill_count) + CNT_W'(1))
    else $error("append did not grow the list");

endmodule
